// ===== sv/necir_pkg.sv =====
// Shared types and constants for the infrared frame transmitter.
`default_nettype none

package necir_pkg;

    // Configuration port geometry
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MARK_TICKS  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SPACE_TICKS = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_MARK_TICKS     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE_TICKS   = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE_TICKS    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_GAP_TICKS   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_SPACE_TICKS = 4'd7;

    // Reset values of the timing registers
    localparam logic [7:0]  RST_DEVICE_ADDRESS     = 8'd0;
    localparam logic [11:0] RST_HEADER_MARK_TICKS  = 12'd690;
    localparam logic [11:0] RST_HEADER_SPACE_TICKS = 12'd340;
    localparam logic [9:0]  RST_BIT_MARK_TICKS     = 10'd43;
    localparam logic [9:0]  RST_ZERO_SPACE_TICKS   = 10'd43;
    localparam logic [9:0]  RST_ONE_SPACE_TICKS    = 10'd130;
    localparam logic [15:0] RST_REPEAT_GAP_TICKS   = 16'd1769;
    localparam logic [11:0] RST_REPEAT_SPACE_TICKS = 12'd170;

    // Fixed segment lengths
    localparam logic [15:0] STOP_MARK_TICKS = 16'd34;
    localparam logic [15:0] END_BURST_TICKS = 16'd50;

    // Last bit position of the 32-bit frame
    localparam logic [4:0] LAST_BIT = 5'd31;

    // Timing register file contents
    typedef struct packed {
        logic [7:0]  device_address;
        logic [11:0] header_mark_ticks;
        logic [11:0] header_space_ticks;
        logic [9:0]  bit_mark_ticks;
        logic [9:0]  zero_space_ticks;
        logic [9:0]  one_space_ticks;
        logic [15:0] repeat_gap_ticks;
        logic [11:0] repeat_space_ticks;
    } necir_cfg_t;

    // One result beat
    typedef struct packed {
        logic frame_done;
        logic busy_res;
        logic ir_level;
    } necir_result_t;

endpackage

`default_nettype wire

// ===== sv/necir_cfg.sv =====
// Configuration register file for the infrared frame transmitter.
`default_nettype none

module necir_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                wr_en,
    input  wire logic [necir_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [necir_pkg::CFG_DATA_W-1:0]    wr_data,
    output necir_pkg::necir_cfg_t                    cfg
);

    necir_pkg::necir_cfg_t cfg_reg;
    necir_pkg::necir_cfg_t cfg_next;

    // Register decode; indexes past the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                necir_pkg::REG_DEVICE_ADDRESS:     cfg_next.device_address     = wr_data[7:0];
                necir_pkg::REG_HEADER_MARK_TICKS:  cfg_next.header_mark_ticks  = wr_data[11:0];
                necir_pkg::REG_HEADER_SPACE_TICKS: cfg_next.header_space_ticks = wr_data[11:0];
                necir_pkg::REG_BIT_MARK_TICKS:     cfg_next.bit_mark_ticks     = wr_data[9:0];
                necir_pkg::REG_ZERO_SPACE_TICKS:   cfg_next.zero_space_ticks   = wr_data[9:0];
                necir_pkg::REG_ONE_SPACE_TICKS:    cfg_next.one_space_ticks    = wr_data[9:0];
                necir_pkg::REG_REPEAT_GAP_TICKS:   cfg_next.repeat_gap_ticks   = wr_data[15:0];
                necir_pkg::REG_REPEAT_SPACE_TICKS: cfg_next.repeat_space_ticks = wr_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address     <= necir_pkg::RST_DEVICE_ADDRESS;
            cfg_reg.header_mark_ticks  <= necir_pkg::RST_HEADER_MARK_TICKS;
            cfg_reg.header_space_ticks <= necir_pkg::RST_HEADER_SPACE_TICKS;
            cfg_reg.bit_mark_ticks     <= necir_pkg::RST_BIT_MARK_TICKS;
            cfg_reg.zero_space_ticks   <= necir_pkg::RST_ZERO_SPACE_TICKS;
            cfg_reg.one_space_ticks    <= necir_pkg::RST_ONE_SPACE_TICKS;
            cfg_reg.repeat_gap_ticks   <= necir_pkg::RST_REPEAT_GAP_TICKS;
            cfg_reg.repeat_space_ticks <= necir_pkg::RST_REPEAT_SPACE_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/necir_core.sv =====
// Frame sequencer: segment state, tick counter, bit shifter and carrier.
`default_nettype none

module necir_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  necir_pkg::necir_cfg_t      cfg,
    input  wire logic                  step,       // process one item this cycle
    input  wire logic                  cmd,        // 1 = send, 0 = tick
    input  wire logic [7:0]            data_byte,
    output necir_pkg::necir_result_t   result      // result of the item in step
);

    typedef enum logic [3:0] {
        SEG_IDLE,
        SEG_HDR_MARK,
        SEG_HDR_SPACE,
        SEG_BIT_MARK,
        SEG_BIT_SPACE,
        SEG_STOP_MARK,
        SEG_GAP,
        SEG_REP_MARK,
        SEG_REP_SPACE,
        SEG_END_BURST
    } seg_t;

    seg_t        seg_reg,     seg_next;
    logic [15:0] tick_reg,    tick_next;
    logic [4:0]  bit_idx_reg, bit_idx_next;
    logic [31:0] bits_reg,    bits_next;
    logic        phase_reg,   phase_next;
    logic        idle_lvl_reg, idle_lvl_next;

    logic [15:0] seg_len_raw;
    logic [15:0] seg_len;
    logic        seg_mark;
    logic [15:0] tick_inc;
    logic        pin_now;
    logic        level;
    logic        done;

    // Length of the current segment; zero counts as one tick
    always_comb begin
        unique case (seg_reg)
            SEG_HDR_MARK:  seg_len_raw = {4'd0, cfg.header_mark_ticks};
            SEG_HDR_SPACE: seg_len_raw = {4'd0, cfg.header_space_ticks};
            SEG_BIT_MARK:  seg_len_raw = {6'd0, cfg.bit_mark_ticks};
            SEG_BIT_SPACE: seg_len_raw = bits_reg[31] ? {6'd0, cfg.one_space_ticks}
                                                      : {6'd0, cfg.zero_space_ticks};
            SEG_STOP_MARK: seg_len_raw = necir_pkg::STOP_MARK_TICKS;
            SEG_GAP:       seg_len_raw = cfg.repeat_gap_ticks;
            SEG_REP_MARK:  seg_len_raw = {4'd0, cfg.header_mark_ticks};
            SEG_REP_SPACE: seg_len_raw = {4'd0, cfg.repeat_space_ticks};
            default:       seg_len_raw = necir_pkg::END_BURST_TICKS;
        endcase
        seg_len = (seg_len_raw == 16'd0) ? 16'd1 : seg_len_raw;
    end

    assign seg_mark = (seg_reg == SEG_HDR_MARK) || (seg_reg == SEG_BIT_MARK) ||
                      (seg_reg == SEG_STOP_MARK) || (seg_reg == SEG_REP_MARK) ||
                      (seg_reg == SEG_END_BURST);

    assign tick_inc = tick_reg + 16'd1;

    // Pin as seen without a tick; before the first header tick it keeps idle level
    assign pin_now = ((seg_reg == SEG_IDLE) ||
                      ((seg_reg == SEG_HDR_MARK) && (tick_reg == 16'd0)))
                     ? idle_lvl_reg : phase_reg;

    // Next state for one item
    always_comb begin
        seg_next      = seg_reg;
        tick_next     = tick_reg;
        bit_idx_next  = bit_idx_reg;
        bits_next     = bits_reg;
        phase_next    = phase_reg;
        idle_lvl_next = idle_lvl_reg;
        level         = pin_now;
        done          = 1'b0;

        if (cmd) begin
            // Start a frame only from idle; level stays the idle level
            if (seg_reg == SEG_IDLE) begin
                bits_next    = {cfg.device_address, ~cfg.device_address,
                                data_byte, ~data_byte};
                seg_next     = SEG_HDR_MARK;
                tick_next    = 16'd0;
                bit_idx_next = 5'd0;
                level        = idle_lvl_reg;
            end
        end else if (seg_reg != SEG_IDLE) begin
            phase_next = seg_mark ? ~phase_reg : 1'b0;
            level      = phase_next;
            tick_next  = tick_inc;
            if (tick_inc >= seg_len) begin
                tick_next = 16'd0;
                unique case (seg_reg)
                    SEG_HDR_MARK:  seg_next = SEG_HDR_SPACE;
                    SEG_HDR_SPACE: seg_next = SEG_BIT_MARK;
                    SEG_BIT_MARK:  seg_next = SEG_BIT_SPACE;
                    SEG_BIT_SPACE: begin
                        bits_next = {bits_reg[30:0], 1'b0};
                        if (bit_idx_reg == necir_pkg::LAST_BIT) begin
                            bit_idx_next = 5'd0;
                            seg_next     = SEG_STOP_MARK;
                        end else begin
                            bit_idx_next = bit_idx_reg + 5'd1;
                            seg_next     = SEG_BIT_MARK;
                        end
                    end
                    SEG_STOP_MARK: begin
                        seg_next   = SEG_GAP;
                        phase_next = 1'b0;
                    end
                    SEG_GAP:       seg_next = SEG_REP_MARK;
                    SEG_REP_MARK:  seg_next = SEG_REP_SPACE;
                    SEG_REP_SPACE: seg_next = SEG_END_BURST;
                    default: begin
                        // End burst finished: pin goes high and stays there
                        seg_next      = SEG_IDLE;
                        idle_lvl_next = 1'b1;
                        level         = 1'b1;
                        done          = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg      <= SEG_IDLE;
            tick_reg     <= 16'd0;
            bit_idx_reg  <= 5'd0;
            bits_reg     <= 32'd0;
            phase_reg    <= 1'b0;
            idle_lvl_reg <= 1'b0;
        end else if (step) begin
            seg_reg      <= seg_next;
            tick_reg     <= tick_next;
            bit_idx_reg  <= bit_idx_next;
            bits_reg     <= bits_next;
            phase_reg    <= phase_next;
            idle_lvl_reg <= idle_lvl_next;
        end
    end

    assign result.ir_level   = level;
    assign result.busy_res   = (seg_next != SEG_IDLE);
    assign result.frame_done = done;

endmodule

`default_nettype wire

// ===== sv/nec_ir_frame_transmitter.sv =====
// Top level of the pulse-distance infrared frame transmitter.
//
// Input stream (s_*): one beat per item. s_tuser is the command: 0 means one
// 13 us timer tick has passed, 1 starts a frame with the byte in s_tdata.
// A start while a frame is in progress is ignored but still answered.
// Result stream (m_*): exactly one beat per input beat, in order. m_tdata
// carries the emitter pin level and the busy flag; m_tlast marks the tick
// that ends the frame.
// Configuration (cfg_*): index 0..7 selects a timing register, always ready;
// write only while the block is idle.
// Timing: an input beat is registered, processed by the sequencer once the
// result slot is free, and its result registered in turn. One beat per
// cycle is sustained while m_tready stays high; the sequencer takes one
// beat in each step that it is given.
// Reset: the pin reads 0, no frame is active, registers take their defaults.
// When m_tready is low the result register holds and the input register
// fills; s_tready drops only once both are occupied.
`default_nettype none

module nec_ir_frame_transmitter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  wire logic                                s_tuser,   // [0] cmd
    // result stream
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [7:0]                          m_tdata,   // [0] ir_level, [1] busy_res
    output      logic                                m_tlast,   // frame_done
    // configuration writes
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [necir_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [necir_pkg::CFG_DATA_W-1:0]    cfg_data
);

    necir_pkg::necir_cfg_t    cfg;
    necir_pkg::necir_result_t core_res;

    logic                     in_valid_reg, in_valid_next;
    logic                     in_cmd_reg;
    logic [7:0]               in_data_reg;
    logic                     out_valid_reg, out_valid_next;
    necir_pkg::necir_result_t out_res_reg;

    logic advance;
    logic step;
    logic s_fire;

    assign cfg_ready = 1'b1;

    necir_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the result slot frees when empty or taken this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    necir_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .cmd       (in_cmd_reg),
        .data_byte (in_data_reg),
        .result    (core_res)
    );

    // Input and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (step) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.busy_res, out_res_reg.ir_level};
    assign m_tlast  = out_res_reg.frame_done;

endmodule

`default_nettype wire

// ===== tb/necir_emitter_checker.sv =====
// Result checker for the infrared frame transmitter: predicts every result beat and compares.
module necir_emitter_checker
    import necir_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,    // [7:0] data_byte
    input  logic                   s_tuser,    // [0] cmd
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [7:0]             m_tdata,    // [0] ir_level, [1] busy_res
    input  logic                   m_tlast,    // frame_done
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP,
        PH_GAP,
        PH_RPT_MARK,
        PH_RPT_SPACE,
        PH_TAIL
    } burst_phase_e;

    // Shadow of the timing registers and of the sequencer
    necir_cfg_t   timing;
    burst_phase_e phase;
    logic [15:0]  tick_cnt;
    logic [4:0]   bit_pos;
    logic [31:0]  frame_word;
    logic         carrier;
    logic         rest_level;

    necir_result_t expected_pin_beats[$];
    int            mismatches = 0;
    int            beat_no = 0;

    // Length of the current phase in ticks; a zero register still lasts one tick
    function automatic logic [15:0] phase_ticks();
        logic [15:0] n;
        case (phase)
            PH_LEAD_MARK:  n = 16'(timing.header_mark_ticks);
            PH_LEAD_SPACE: n = 16'(timing.header_space_ticks);
            PH_BIT_MARK:   n = 16'(timing.bit_mark_ticks);
            PH_BIT_SPACE:  n = frame_word[31] ? 16'(timing.one_space_ticks)
                                              : 16'(timing.zero_space_ticks);
            PH_STOP:       n = STOP_MARK_TICKS;
            PH_GAP:        n = timing.repeat_gap_ticks;
            PH_RPT_MARK:   n = 16'(timing.header_mark_ticks);
            PH_RPT_SPACE:  n = 16'(timing.repeat_space_ticks);
            default:       n = END_BURST_TICKS;
        endcase
        return (n == 16'd0) ? 16'd1 : n;
    endfunction

    function automatic logic phase_is_mark();
        return phase == PH_LEAD_MARK || phase == PH_BIT_MARK || phase == PH_STOP ||
               phase == PH_RPT_MARK || phase == PH_TAIL;
    endfunction

    // Advance the sequencer by one input beat and return the result it causes
    function automatic necir_result_t step_emitter(input logic cmd, input logic [7:0] data);
        necir_result_t res;
        logic [15:0]   len;
        logic          lvl;
        logic          done;
        done = 1'b0;
        if (cmd) begin
            // start is ignored while a frame runs; no time passes either way
            if (phase == PH_IDLE) begin
                frame_word = {timing.device_address, ~timing.device_address, data, ~data};
                phase      = PH_LEAD_MARK;
                tick_cnt   = 16'd0;
                bit_pos    = 5'd0;
            end
            if (phase == PH_IDLE || (phase == PH_LEAD_MARK && tick_cnt == 16'd0))
                lvl = rest_level;
            else
                lvl = carrier;
        end else if (phase == PH_IDLE) begin
            lvl = rest_level;
        end else begin
            len = phase_ticks();
            carrier = phase_is_mark() ? ~carrier : 1'b0;
            lvl = carrier;
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= len) begin
                tick_cnt = 16'd0;
                case (phase)
                    PH_LEAD_MARK:  phase = PH_LEAD_SPACE;
                    PH_LEAD_SPACE: phase = PH_BIT_MARK;
                    PH_BIT_MARK:   phase = PH_BIT_SPACE;
                    PH_BIT_SPACE: begin
                        frame_word = frame_word << 1;
                        if (bit_pos >= LAST_BIT) begin
                            bit_pos = 5'd0;
                            phase   = PH_STOP;
                        end else begin
                            bit_pos = bit_pos + 5'd1;
                            phase   = PH_BIT_MARK;
                        end
                    end
                    PH_STOP: begin
                        phase   = PH_GAP;
                        carrier = 1'b0;
                    end
                    PH_GAP:       phase = PH_RPT_MARK;
                    PH_RPT_MARK:  phase = PH_RPT_SPACE;
                    PH_RPT_SPACE: phase = PH_TAIL;
                    default: begin
                        // end burst over: pin parks high
                        phase      = PH_IDLE;
                        rest_level = 1'b1;
                        lvl        = 1'b1;
                        done       = 1'b1;
                    end
                endcase
            end
        end
        res.ir_level   = lvl;
        res.busy_res   = (phase != PH_IDLE);
        res.frame_done = done;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        mismatches++;
        $display("mismatch at result beat %0d, %s: expected %b, got %b",
                 beat_no, what, want, got);
    endtask

    // Watch the three channels; pop before push since a result lags its input
    always @(posedge aclk) begin
        necir_result_t want;
        if (!aresetn) begin
            timing.device_address     = RST_DEVICE_ADDRESS;
            timing.header_mark_ticks  = RST_HEADER_MARK_TICKS;
            timing.header_space_ticks = RST_HEADER_SPACE_TICKS;
            timing.bit_mark_ticks     = RST_BIT_MARK_TICKS;
            timing.zero_space_ticks   = RST_ZERO_SPACE_TICKS;
            timing.one_space_ticks    = RST_ONE_SPACE_TICKS;
            timing.repeat_gap_ticks   = RST_REPEAT_GAP_TICKS;
            timing.repeat_space_ticks = RST_REPEAT_SPACE_TICKS;
            phase      = PH_IDLE;
            tick_cnt   = 16'd0;
            bit_pos    = 5'd0;
            frame_word = 32'd0;
            carrier    = 1'b0;
            rest_level = 1'b0;
            expected_pin_beats.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEVICE_ADDRESS:     timing.device_address     = cfg_data[7:0];
                    REG_HEADER_MARK_TICKS:  timing.header_mark_ticks  = cfg_data[11:0];
                    REG_HEADER_SPACE_TICKS: timing.header_space_ticks = cfg_data[11:0];
                    REG_BIT_MARK_TICKS:     timing.bit_mark_ticks     = cfg_data[9:0];
                    REG_ZERO_SPACE_TICKS:   timing.zero_space_ticks   = cfg_data[9:0];
                    REG_ONE_SPACE_TICKS:    timing.one_space_ticks    = cfg_data[9:0];
                    REG_REPEAT_GAP_TICKS:   timing.repeat_gap_ticks   = cfg_data[15:0];
                    REG_REPEAT_SPACE_TICKS: timing.repeat_space_ticks = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_pin_beats.size() == 0) begin
                    report_mismatch("unexpected beat, tvalid", 1'b0, 1'b1);
                end else begin
                    want = expected_pin_beats.pop_front();
                    if (m_tdata[0] !== want.ir_level)
                        report_mismatch("ir_level", want.ir_level, m_tdata[0]);
                    if (m_tdata[1] !== want.busy_res)
                        report_mismatch("busy_res", want.busy_res, m_tdata[1]);
                    if (m_tlast !== want.frame_done)
                        report_mismatch("frame_done", want.frame_done, m_tlast);
                end
                beat_no++;
            end
            if (s_tvalid && s_tready)
                expected_pin_beats.push_back(step_emitter(s_tuser, s_tdata));
        end
        pending    <= expected_pin_beats.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/nec_ir_frame_transmitter_tb.sv =====
// Testbench top for the infrared frame transmitter: stimulus, idling, watchdog and verdict.
module nec_ir_frame_transmitter_tb;
    import necir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int RANDOM_BEATS   = 130;
    localparam int RANDOM_PHASES  = 4;
    localparam int LEAD_TICKS     = 48;
    localparam int START_PCT      = 6;
    localparam logic [CFG_INDEX_W-1:0] FIRST_SPARE_INDEX = REG_REPEAT_SPACE_TICKS + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] LAST_SPARE_INDEX  = '1;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = 8'd0;     // [7:0] data_byte
    logic                   s_tuser = 1'b0;     // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;            // [0] ir_level, [1] busy_res
    logic                   m_tlast;            // frame_done
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int fail_count;
    int pending;

    // Stimulus knobs and bookkeeping
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          frames_seen = 0;
    logic        busy_seen = 1'b0;
    int          quiet_cycles = 0;
    int          beats_sent = 0;
    int          starts_sent = 0;
    int          cfg_writes = 0;
    int          settings_used = 0;
    logic [15:0] shadow_regs [0:15];

    nec_ir_frame_transmitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    necir_emitter_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Frame progress as seen on the result side, and the stall watchdog
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            busy_seen <= m_tdata[1];
            if (m_tlast)
                frames_seen <= frames_seen + 1;
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int reg_bits(input logic [CFG_INDEX_W-1:0] idx);
        case (idx)
            REG_DEVICE_ADDRESS:     return 8;
            REG_HEADER_MARK_TICKS:  return 12;
            REG_HEADER_SPACE_TICKS: return 12;
            REG_BIT_MARK_TICKS:     return 10;
            REG_ZERO_SPACE_TICKS:   return 10;
            REG_ONE_SPACE_TICKS:    return 10;
            REG_REPEAT_GAP_TICKS:   return 16;
            REG_REPEAT_SPACE_TICKS: return 12;
            default:                return 0;
        endcase
    endfunction

    function automatic int at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 1 : int'(v);
    endfunction

    // Generous tick budget for one frame under the current settings
    function automatic int frame_tick_bound();
        int zero_len;
        int one_len;
        int bit_len;
        zero_len = at_least_one(shadow_regs[REG_ZERO_SPACE_TICKS]);
        one_len  = at_least_one(shadow_regs[REG_ONE_SPACE_TICKS]);
        bit_len  = at_least_one(shadow_regs[REG_BIT_MARK_TICKS]) +
                   ((zero_len > one_len) ? zero_len : one_len);
        return 2 * (2 * at_least_one(shadow_regs[REG_HEADER_MARK_TICKS]) +
                    at_least_one(shadow_regs[REG_HEADER_SPACE_TICKS]) + 32 * bit_len +
                    at_least_one(shadow_regs[REG_REPEAT_GAP_TICKS]) +
                    at_least_one(shadow_regs[REG_REPEAT_SPACE_TICKS]) +
                    int'(STOP_MARK_TICKS) + int'(END_BURST_TICKS) + 64);
    endfunction

    // Short timing value, sometimes with junk above the register width
    function automatic logic [15:0] short_ticks(input int width);
        logic [15:0] v;
        v = ($urandom_range(99) < 85) ? 16'($urandom_range(3)) : 16'($urandom_range(12, 4));
        if (width < 16 && $urandom_range(3) == 0)
            v = v | (16'($urandom) << width);
        return v;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (reg_bits(idx) != 0)
            shadow_regs[idx] = 16'(value & ((17'd1 << reg_bits(idx)) - 17'd1));
        cfg_writes++;
    endtask

    // Offer one input beat after a random gap; returns on the accepting edge
    task automatic push_beat(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (cmd)
            starts_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // Tick until the running frame ends, with occasional starts thrown in while busy
    task automatic tick_through_frame(input int busy_start_pct);
        int start_count;
        int n;
        int tries;
        tries = 0;
        do begin
            start_count = frames_seen;
            n = 0;
            while (frames_seen == start_count && n < frame_tick_bound()) begin
                push_beat($urandom_range(99) < busy_start_pct, 8'($urandom_range(255)));
                n++;
            end
            drain_results();
            tries++;
        end while (busy_seen && tries < 4);
    endtask

    task automatic randomize_settings();
        write_register(REG_DEVICE_ADDRESS, 16'($urandom));
        write_register(REG_HEADER_MARK_TICKS, short_ticks(12));
        write_register(REG_HEADER_SPACE_TICKS, short_ticks(12));
        write_register(REG_BIT_MARK_TICKS, short_ticks(10));
        write_register(REG_ZERO_SPACE_TICKS, short_ticks(10));
        write_register(REG_ONE_SPACE_TICKS, short_ticks(10));
        write_register(REG_REPEAT_GAP_TICKS, short_ticks(16));
        write_register(REG_REPEAT_SPACE_TICKS, short_ticks(12));
        if ($urandom_range(1) == 1)
            write_register(4'($urandom_range(LAST_SPARE_INDEX, FIRST_SPARE_INDEX)),
                           16'($urandom));
        settings_used++;
    endtask

    initial begin
        shadow_regs[REG_DEVICE_ADDRESS]     = 16'(RST_DEVICE_ADDRESS);
        shadow_regs[REG_HEADER_MARK_TICKS]  = 16'(RST_HEADER_MARK_TICKS);
        shadow_regs[REG_HEADER_SPACE_TICKS] = 16'(RST_HEADER_SPACE_TICKS);
        shadow_regs[REG_BIT_MARK_TICKS]     = 16'(RST_BIT_MARK_TICKS);
        shadow_regs[REG_ZERO_SPACE_TICKS]   = 16'(RST_ZERO_SPACE_TICKS);
        shadow_regs[REG_ONE_SPACE_TICKS]    = 16'(RST_ONE_SPACE_TICKS);
        shadow_regs[REG_REPEAT_GAP_TICKS]   = 16'(RST_REPEAT_GAP_TICKS);
        shadow_regs[REG_REPEAT_SPACE_TICKS] = 16'(RST_REPEAT_SPACE_TICKS);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle ticks, start, start right away again, early header ticks
        settings_used++;
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b1, 8'hA5);
        push_beat(1'b1, 8'h3C);
        for (int i = 0; i < LEAD_TICKS; i++)
            push_beat(1'b0, 8'($urandom_range(255)));
        drain_results();

        // All lengths zero (one tick each), address all ones, junk above the widths;
        // the frame already running finishes under these lengths
        write_register(REG_DEVICE_ADDRESS, 16'h5AFF);
        write_register(REG_HEADER_MARK_TICKS, 16'hF000);
        write_register(REG_HEADER_SPACE_TICKS, 16'h0000);
        write_register(REG_BIT_MARK_TICKS, 16'hFC00);
        write_register(REG_ZERO_SPACE_TICKS, 16'h0000);
        write_register(REG_ONE_SPACE_TICKS, 16'h0400);
        write_register(REG_REPEAT_GAP_TICKS, 16'h0000);
        write_register(REG_REPEAT_SPACE_TICKS, 16'h0000);
        write_register(FIRST_SPARE_INDEX, 16'hFFFF);
        write_register(LAST_SPARE_INDEX, 16'h1234);
        settings_used++;
        tick_through_frame(1);
        push_beat(1'b1, 8'h81);
        push_beat(1'b0, 8'h7E);
        tick_through_frame(3);

        // Every register at its maximum, address zero; the frame starts long and
        // is finished under the first random settings
        write_register(REG_DEVICE_ADDRESS, 16'hFF00);
        write_register(REG_HEADER_MARK_TICKS, 16'hFFFF);
        write_register(REG_HEADER_SPACE_TICKS, 16'hFFFF);
        write_register(REG_BIT_MARK_TICKS, 16'hFFFF);
        write_register(REG_ZERO_SPACE_TICKS, 16'hFFFF);
        write_register(REG_ONE_SPACE_TICKS, 16'hFFFF);
        write_register(REG_REPEAT_GAP_TICKS, 16'hFFFF);
        write_register(REG_REPEAT_SPACE_TICKS, 16'hFFFF);
        settings_used++;
        push_beat(1'b1, 8'h5A);
        for (int i = 0; i < LEAD_TICKS; i++)
            push_beat(1'b0, 8'($urandom_range(255)));
        drain_results();

        // Random phases with short timings, cycling through the idling modes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            randomize_settings();
            for (int i = 0; i < RANDOM_BEATS; i++) begin
                // back-pressure: result side holds off while beats keep coming
                if (p == 0 && i == RANDOM_BEATS / 2)
                    hold_requests++;
                if (p == 3 && i == RANDOM_BEATS / 3)
                    drain_results();
                push_beat($urandom_range(99) < START_PCT, 8'($urandom_range(255)));
            end
            drain_results();
            if (busy_seen)
                tick_through_frame(0);
        end

        drain_results();
        repeat (20) @(posedge aclk);
        $display("summary: %0d input beats, %0d of them starts, %0d frames ended",
                 beats_sent, starts_sent, frames_seen);
        $display("summary: %0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, settings_used, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
